// ===== rtl/gckv_pkg.sv =====
// Shared types and constants of the grid cell key vicinity unit.
// No dependencies; every other file of the block imports this package.
package gckv_pkg;

  // Field widths and grid geometry.
  localparam int unsigned KEY_BITS    = 15;
  localparam int unsigned MAX_SPAN    = 8;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned STEP_W      = 23;
  localparam int unsigned RAD_W       = 23;
  localparam int unsigned KEY_W       = 30;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Derived widths: doubled coordinates, divider operands, multiplier.
  localparam int unsigned IDX_W  = KEY_BITS;
  localparam int unsigned SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int unsigned C2_W   = COORD_W + 2;
  localparam int unsigned V_W    = C2_W + 1;
  localparam int unsigned N_W    = V_W;
  localparam int unsigned D_W    = STEP_W + 1;
  localparam int unsigned MUL_W  = RAD_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned CEN_W  = PROD_W + 2;

  // Query kinds.
  localparam logic [KIND_W-1:0] KIND_KEY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VIC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CIRC = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [KEY_W-1:0]          cell_key;
    logic [RAD_W-1:0]          radius;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
  } cfg_t;

  typedef struct packed {
    logic           start;
    logic [N_W-1:0] num;
    logic [D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]  fst;
    logic [SPAN_W-1:0] cnt;
  } win_t;

endpackage

// ===== rtl/gckv_front.sv =====
// Front end: accepts query beats, drops unused kinds and queues the rest.
// Depends on gckv_pkg.
module gckv_front
  import gckv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  output logic  head_valid_o,
  output item_t head_o,
  input  logic  pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push;

  // An item of the unused kind causes no result, so it is not queued.
  assign in_stall_o   = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o && (item_i.kind != KIND_NONE);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/gckv_div.sv =====
// Iterative divider giving a cell index, saturated at the largest index.
// One quotient bit per cycle. Depends on gckv_pkg.
module gckv_div
  import gckv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned DS_W  = D_W + KEY_BITS;
  localparam int unsigned CNT_W = $clog2(KEY_BITS + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   rem_q;
  logic [DS_W-1:0]  ds_q;
  logic [IDX_W-1:0] quo_q;
  logic             sat, ge;
  logic [DS_W-1:0]  rem_ext;

  // A quotient that does not fit the index width saturates at once.
  assign sat     = DS_W'(req_i.num) >= (DS_W'(req_i.den) << KEY_BITS);
  assign rem_ext = DS_W'(rem_q);
  assign ge      = rem_ext >= ds_q;

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= CNT_W'(KEY_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division, shifted divisor walking down one bit a cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      ds_q  <= DS_W'(req_i.den) << (KEY_BITS - 1);
      quo_q <= sat ? '1 : '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= N_W'(rem_ext - ds_q);
      end
      ds_q  <= ds_q >> 1;
      quo_q <= {quo_q[IDX_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/gckv_back.sv =====
// Back end: sequencer that indexes, windows and lists cell keys per query.
// Depends on gckv_pkg and drives the shared gckv_div divider.
module gckv_back
  import gckv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             head_valid_i,
  input  item_t            head_i,
  output logic             pop_o,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [KEY_W-1:0] result_key_o,
  output logic             out_of_range_o,
  output logic             last_o
);

  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_RR    = 5'd1;
  localparam logic [ST_W-1:0] S_CHECK = 5'd2;
  localparam logic [ST_W-1:0] S_DIVGO = 5'd3;
  localparam logic [ST_W-1:0] S_DIVW  = 5'd4;
  localparam logic [ST_W-1:0] S_KCHK  = 5'd5;
  localparam logic [ST_W-1:0] S_CX1   = 5'd6;
  localparam logic [ST_W-1:0] S_CY1   = 5'd7;
  localparam logic [ST_W-1:0] S_WIN   = 5'd8;
  localparam logic [ST_W-1:0] S_FX0   = 5'd9;
  localparam logic [ST_W-1:0] S_FXS   = 5'd10;
  localparam logic [ST_W-1:0] S_FYS   = 5'd11;
  localparam logic [ST_W-1:0] S_C0    = 5'd12;
  localparam logic [ST_W-1:0] S_C1    = 5'd13;
  localparam logic [ST_W-1:0] S_C2    = 5'd14;
  localparam logic [ST_W-1:0] S_C3    = 5'd15;
  localparam logic [ST_W-1:0] S_PUT   = 5'd16;
  localparam logic [ST_W-1:0] S_NEXT  = 5'd17;
  localparam logic [ST_W-1:0] S_FIN   = 5'd18;
  localparam logic [ST_W-1:0] S_OOR   = 5'd19;
  localparam logic [ST_W-1:0] S_KEY   = 5'd20;

  // Division jobs.
  localparam logic [2:0] J_HX   = 3'd0;
  localparam logic [2:0] J_HY   = 3'd1;
  localparam logic [2:0] J_OWNX = 3'd2;
  localparam logic [2:0] J_HIX  = 3'd3;
  localparam logic [2:0] J_LOX  = 3'd4;
  localparam logic [2:0] J_OWNY = 3'd5;
  localparam logic [2:0] J_HIY  = 3'd6;
  localparam logic [2:0] J_LOY  = 3'd7;

  localparam logic [IDX_W-1:0] HALF = IDX_W'((MAX_SPAN - 1) / 2);

  // Clamps the lower window edge around the own cell and cuts the span.
  function automatic win_t axis_win(input logic [IDX_W-1:0] own,
                                    input logic [IDX_W-1:0] hi,
                                    input logic [IDX_W-1:0] lo);
    logic [IDX_W-1:0] l;
    logic [IDX_W-1:0] h;
    win_t             w;
    l = lo;
    if (own >= HALF && lo < own - HALF) begin
      l = own - HALF;
    end
    h = (hi < l) ? l : hi;
    w.fst = l;
    if (h - l >= IDX_W'(MAX_SPAN)) begin
      w.cnt = SPAN_W'(MAX_SPAN);
    end else begin
      w.cnt = SPAN_W'(h - l) + 1'b1;
    end
    return w;
  endfunction

  logic [ST_W-1:0] state_q, state_d;
  logic [2:0]      job_q, job_d;
  logic            pend_v_q, pend_load, pend_clr;
  logic            out_valid_q, out_we, out_free;
  logic [KEY_W-1:0] out_key_q, out_key_d, pend_key_q, cand_q, cell_key;
  logic            out_oor_q, out_oor_d, out_last_q, out_last_d;

  // Query operands.
  logic [KIND_W-1:0]       kind_q;
  logic signed [C2_W-1:0]  px2_q, py2_q;
  logic [MUL_W-1:0]        r2_q;
  logic [KEY_W-KEY_BITS-1:0] kx_q;
  logic [IDX_W-1:0]        ky_q;
  logic [IDX_W-1:0]        idx_hx_q, idx_hy_q;
  logic [IDX_W-1:0]        own_x_q, hi_x_q, lo_x_q, own_y_q, hi_y_q, lo_y_q;
  logic [IDX_W-1:0]        fx_q, fy_q, ki, kj;
  logic [SPAN_W-1:0]       nx_q, ny_q, ci_q, cj_q;
  logic [PROD_W-1:0]       prod_q, rr_q, sqx_q;
  logic [MUL_W-1:0]        mul_a, mul_b, dx_q, dy_q;
  logic                    near_q;
  logic signed [CEN_W-1:0] cx_q, cy_q, cy0_q;

  // Box geometry in doubled coordinates.
  logic signed [C2_W-1:0]  lx2, ly2, hx2, hy2;
  logic [STEP_W-1:0]       sx, sy;
  logic [D_W-1:0]          sx2, sy2;
  logic                    box_empty, pt_oor, key_oor;
  win_t                    win_x, win_y;

  // Division operand selection.
  logic                    axis_x;
  logic signed [C2_W-1:0]  ax_lo, ax_hi, ax_p;
  logic signed [V_W-1:0]   lo_v, hi_v, p_v, r_v, pp, pm, sel_v, diff_v;

  // Centre arithmetic.
  logic signed [CEN_W-1:0] lx_c, ly_c, hx_c, hy_c, px_c, py_c, r_c, prod_c;
  logic signed [CEN_W-1:0] cen_x, cen_y, cen_xc, cen_yc;
  logic signed [CEN_W-1:0] cxc, cyc, dxs, dys, dxa, dya;
  logic [PROD_W:0]         sq_sum;
  logic                    pass;

  assign lx2 = {cfg_i.box_min_x[COORD_W-1], cfg_i.box_min_x, 1'b0};
  assign ly2 = {cfg_i.box_min_y[COORD_W-1], cfg_i.box_min_y, 1'b0};
  assign hx2 = {cfg_i.box_max_x[COORD_W-1], cfg_i.box_max_x, 1'b0};
  assign hy2 = {cfg_i.box_max_y[COORD_W-1], cfg_i.box_max_y, 1'b0};
  assign sx  = (cfg_i.step_x == '0) ? STEP_W'(1) : cfg_i.step_x;
  assign sy  = (cfg_i.step_y == '0) ? STEP_W'(1) : cfg_i.step_y;
  assign sx2 = {sx, 1'b0};
  assign sy2 = {sy, 1'b0};

  assign box_empty = (lx2 > hx2) || (ly2 > hy2);
  assign pt_oor    = (px2_q < lx2) || (px2_q > hx2) || (py2_q < ly2) || (py2_q > hy2);
  assign key_oor   = (KEY_W'(kx_q) > KEY_W'(idx_hx_q)) || (ky_q > idx_hy_q);
  assign win_x     = axis_win(own_x_q, hi_x_q, lo_x_q);
  assign win_y     = axis_win(own_y_q, hi_y_q, lo_y_q);

  // Value to index for the current job, offset from the axis minimum.
  assign axis_x = (job_q == J_HX) || (job_q == J_OWNX) || (job_q == J_HIX) ||
                  (job_q == J_LOX);
  assign ax_lo  = axis_x ? lx2 : ly2;
  assign ax_hi  = axis_x ? hx2 : hy2;
  assign ax_p   = axis_x ? px2_q : py2_q;
  assign lo_v   = {ax_lo[C2_W-1], ax_lo};
  assign hi_v   = {ax_hi[C2_W-1], ax_hi};
  assign p_v    = {ax_p[C2_W-1], ax_p};
  assign r_v    = $signed({{(V_W - MUL_W){1'b0}}, r2_q});
  assign pp     = p_v + r_v;
  assign pm     = p_v - r_v;

  always_comb begin
    unique case (job_q)
      J_HX, J_HY:     sel_v = hi_v;
      J_OWNX, J_OWNY: sel_v = p_v;
      J_HIX, J_HIY:   sel_v = (pp > hi_v) ? hi_v : pp;
      default:        sel_v = (pm < lo_v) ? lo_v : pm;
    endcase
  end

  assign diff_v          = sel_v - lo_v;
  assign div_req_o.start = (state_q == S_DIVGO);
  assign div_req_o.num   = (sel_v > lo_v) ? N_W'(diff_v) : '0;
  assign div_req_o.den   = axis_x ? sx2 : sy2;

  // Centres: box minimum plus step times odd multiple, clamped to the maximum.
  assign lx_c   = {{(CEN_W - C2_W){lx2[C2_W-1]}}, lx2};
  assign ly_c   = {{(CEN_W - C2_W){ly2[C2_W-1]}}, ly2};
  assign hx_c   = {{(CEN_W - C2_W){hx2[C2_W-1]}}, hx2};
  assign hy_c   = {{(CEN_W - C2_W){hy2[C2_W-1]}}, hy2};
  assign px_c   = {{(CEN_W - C2_W){px2_q[C2_W-1]}}, px2_q};
  assign py_c   = {{(CEN_W - C2_W){py2_q[C2_W-1]}}, py2_q};
  assign r_c    = $signed({{(CEN_W - MUL_W){1'b0}}, r2_q});
  assign prod_c = $signed({{(CEN_W - PROD_W){1'b0}}, prod_q});
  assign cen_x  = lx_c + prod_c;
  assign cen_y  = ly_c + prod_c;
  assign cen_xc = (cen_x > hx_c) ? hx_c : cen_x;
  assign cen_yc = (cen_y > hy_c) ? hy_c : cen_y;

  // Distance of the current cell centre from the query centre.
  assign cxc = (cx_q > hx_c) ? hx_c : cx_q;
  assign cyc = (cy_q > hy_c) ? hy_c : cy_q;
  assign dxs = cxc - px_c;
  assign dys = cyc - py_c;
  assign dxa = (dxs < 0) ? -dxs : dxs;
  assign dya = (dys < 0) ? -dys : dys;

  assign sq_sum = {1'b0, sqx_q} + {1'b0, prod_q};
  assign pass   = near_q && (sq_sum <= {1'b0, rr_q});

  assign ki       = fx_q + IDX_W'(ci_q);
  assign kj       = fy_q + IDX_W'(cj_q);
  assign cell_key = KEY_W'({ki, kj});
  assign out_free = !out_valid_q || !out_stall_i;

  // Shared multiplier operands, one product per cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_RR: begin
        mul_a = r2_q;
        mul_b = r2_q;
      end
      S_KCHK: begin
        mul_a = MUL_W'(sx);
        mul_b = MUL_W'({ky_q[0] & 1'b0, kx_q[IDX_W-1:0], 1'b1});
      end
      S_CX1: begin
        mul_a = MUL_W'(sy);
        mul_b = MUL_W'({ky_q, 1'b1});
      end
      S_FX0: begin
        mul_a = MUL_W'(sx);
        mul_b = MUL_W'({fx_q, 1'b1});
      end
      S_FXS: begin
        mul_a = MUL_W'(sy);
        mul_b = MUL_W'({fy_q, 1'b1});
      end
      S_C1: begin
        mul_a = dx_q;
        mul_b = dx_q;
      end
      S_C2: begin
        mul_a = dy_q;
        mul_b = dy_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    pop_o      = 1'b0;
    out_we     = 1'b0;
    out_key_d  = '0;
    out_oor_d  = 1'b0;
    out_last_d = 1'b0;
    pend_load  = 1'b0;
    pend_clr   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = S_RR;
        end
      end
      S_RR: state_d = S_CHECK;
      S_CHECK: begin
        if (kind_q == KIND_CIRC) begin
          if (box_empty) begin
            state_d = S_OOR;
          end else begin
            job_d   = J_HX;
            state_d = S_DIVGO;
          end
        end else if (pt_oor) begin
          state_d = S_OOR;
        end else begin
          job_d   = J_OWNX;
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: state_d = S_DIVW;
      S_DIVW: begin
        if (div_rsp_i.done) begin
          state_d = S_DIVGO;
          unique case (job_q)
            J_HX:   job_d = J_HY;
            J_HY:   state_d = S_KCHK;
            J_OWNX: job_d = (kind_q == KIND_KEY) ? J_OWNY : J_HIX;
            J_HIX:  job_d = J_LOX;
            J_LOX:  job_d = J_OWNY;
            J_OWNY: begin
              if (kind_q == KIND_KEY) begin
                state_d = S_KEY;
              end else begin
                job_d = J_HIY;
              end
            end
            J_HIY:  job_d = J_LOY;
            default: state_d = S_WIN;
          endcase
        end
      end
      S_KCHK:  state_d = key_oor ? S_OOR : S_CX1;
      S_CX1:   state_d = S_CY1;
      S_CY1: begin
        job_d   = J_OWNX;
        state_d = S_DIVGO;
      end
      S_WIN:   state_d = S_FX0;
      S_FX0:   state_d = S_FXS;
      S_FXS:   state_d = S_FYS;
      S_FYS:   state_d = S_C0;
      S_C0:    state_d = (kind_q == KIND_VIC) ? S_PUT : S_C1;
      S_C1:    state_d = S_C2;
      S_C2:    state_d = S_C3;
      S_C3:    state_d = pass ? S_PUT : S_NEXT;
      S_PUT: begin
        // The held key goes out only once a later key shows it is not last.
        if (!pend_v_q) begin
          pend_load = 1'b1;
          state_d   = S_NEXT;
        end else if (out_free) begin
          out_we    = 1'b1;
          out_key_d = pend_key_q;
          pend_load = 1'b1;
          state_d   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (((cj_q + 1'b1) < ny_q) || ((ci_q + 1'b1) < nx_q)) begin
          state_d = S_C0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_we     = 1'b1;
          out_key_d  = pend_key_q;
          out_last_d = 1'b1;
          pend_clr   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_OOR: begin
        if (out_free) begin
          out_we     = 1'b1;
          out_oor_d  = 1'b1;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_KEY: begin
        if (out_free) begin
          out_we     = 1'b1;
          out_key_d  = KEY_W'({own_x_q, own_y_q});
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_HX;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      if (pend_load) begin
        pend_v_q <= 1'b1;
      end else if (pend_clr) begin
        pend_v_q <= 1'b0;
      end
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (out_we) begin
      out_key_q  <= out_key_d;
      out_oor_q  <= out_oor_d;
      out_last_q <= out_last_d;
    end
    if (pend_load) begin
      pend_key_q <= cand_q;
    end
    unique case (state_q)
      S_IDLE: begin
        kind_q <= head_i.kind;
        px2_q  <= {head_i.point_x[COORD_W-1], head_i.point_x, 1'b0};
        py2_q  <= {head_i.point_y[COORD_W-1], head_i.point_y, 1'b0};
        r2_q   <= {head_i.radius, 1'b0};
        kx_q   <= head_i.cell_key[KEY_W-1:KEY_BITS];
        ky_q   <= head_i.cell_key[KEY_BITS-1:0];
      end
      S_CHECK: rr_q <= prod_q;
      S_DIVW: begin
        if (div_rsp_i.done) begin
          unique case (job_q)
            J_HX:    idx_hx_q <= div_rsp_i.quo;
            J_HY:    idx_hy_q <= div_rsp_i.quo;
            J_OWNX:  own_x_q  <= div_rsp_i.quo;
            J_HIX:   hi_x_q   <= div_rsp_i.quo;
            J_LOX:   lo_x_q   <= div_rsp_i.quo;
            J_OWNY:  own_y_q  <= div_rsp_i.quo;
            J_HIY:   hi_y_q   <= div_rsp_i.quo;
            default: lo_y_q   <= div_rsp_i.quo;
          endcase
        end
      end
      S_CX1: px2_q <= C2_W'(cen_xc);
      S_CY1: py2_q <= C2_W'(cen_yc);
      S_WIN: begin
        fx_q <= win_x.fst;
        nx_q <= win_x.cnt;
        fy_q <= win_y.fst;
        ny_q <= win_y.cnt;
      end
      S_FXS: cx_q <= cen_x;
      S_FYS: begin
        cy_q  <= cen_y;
        cy0_q <= cen_y;
        ci_q  <= '0;
        cj_q  <= '0;
      end
      S_C0: begin
        cand_q <= cell_key;
        dx_q   <= MUL_W'(dxa);
        dy_q   <= MUL_W'(dya);
        near_q <= (dxa <= r_c) && (dya <= r_c);
      end
      S_C2: sqx_q <= prod_q;
      S_NEXT: begin
        // Inner loop over y, outer loop over x.
        if ((cj_q + 1'b1) < ny_q) begin
          cj_q <= cj_q + 1'b1;
          cy_q <= cy_q + $signed({{(CEN_W - D_W){1'b0}}, sy2});
        end else begin
          ci_q <= ci_q + 1'b1;
          cj_q <= '0;
          cy_q <= cy0_q;
          cx_q <= cx_q + $signed({{(CEN_W - D_W){1'b0}}, sx2});
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_key_o   = out_key_q;
  assign out_of_range_o = out_oor_q;
  assign last_o         = out_last_q;

endmodule

// ===== rtl/grid_cell_key_vicinity_unit.sv =====
// Uniform grid cell key unit over a configured 2-D box, Q16.8 coordinates.
// A query is accepted into a two-entry queue and worked on one at a time by a
// sequencer; its time is set by the shared iterative divider, which works out
// each cell index. A point key (kind 0) gives one key, a point vicinity
// (kind 1) lists the cells of its window and a key vicinity within a circle
// (kind 2) checks each candidate cell of its window, up to 64 cells. An
// out-of-box query gives one flagged result (kind 2 after two index divisions
// unless its box is empty).
// Depends on gckv_pkg, gckv_front, gckv_div and gckv_back.
module grid_cell_key_vicinity_unit
  import gckv_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic [KEY_W-1:0]          cell_key_i,
  input  logic [RAD_W-1:0]          radius_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [KEY_W-1:0]          result_key_o,
  output logic                      out_of_range_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_W-1:0]        cfg_data_i
);

  cfg_t     cfg_q;
  item_t    item, head;
  logic     head_valid, pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_min_x <= '0;
      cfg_q.box_min_y <= '0;
      cfg_q.box_max_x <= 24'sh7FFFFF;
      cfg_q.box_max_y <= 24'sh7FFFFF;
      cfg_q.step_x    <= 23'd256;
      cfg_q.step_y    <= 23'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_X:  cfg_q.box_min_x <= cfg_data_i;
        CFG_MIN_Y:  cfg_q.box_min_y <= cfg_data_i;
        CFG_MAX_X:  cfg_q.box_max_x <= cfg_data_i;
        CFG_MAX_Y:  cfg_q.box_max_y <= cfg_data_i;
        CFG_STEP_X: cfg_q.step_x    <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_Y: cfg_q.step_y    <= cfg_data_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input beat packed for the queue.
  assign item.kind     = kind_i;
  assign item.point_x  = point_x_i;
  assign item.point_y  = point_y_i;
  assign item.cell_key = cell_key_i;
  assign item.radius   = radius_i;

  gckv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  gckv_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  gckv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_key_o  (result_key_o),
    .out_of_range_o(out_of_range_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/tb_grid_cell_key_vicinity_unit.sv =====
// Self-checking testbench of the grid cell key vicinity unit.
// Directed table plus random queries, checked against an in-bench predictor.
// Depends on gckv_pkg and grid_cell_key_vicinity_unit.
`timescale 1ns / 100ps

module tb_grid_cell_key_vicinity_unit;
  import gckv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             oor;
    logic             last;
  } cell_res_t;

  // One row of the directed table; a typed expectation is optional.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [23:0]       px;
    logic [23:0]       py;
    logic [KEY_W-1:0]  ckey;
    logic [RAD_W-1:0]  rad;
    bit                typed;
    cell_res_t         res;
  } query_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic signed [COORD_W-1:0] point_x_i = '0;
  logic signed [COORD_W-1:0] point_y_i = '0;
  logic [KEY_W-1:0] cell_key_i = '0;
  logic [RAD_W-1:0] radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KEY_W-1:0] result_key_o;
  logic out_of_range_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COORD_W-1:0] cfg_data_i = '0;

  // Predictor copy of the registers.
  longint g_min_x, g_min_y, g_max_x, g_max_y, g_step_x, g_step_y;
  cell_res_t expected_cells[$];
  query_row_t table_rows[$];
  int errors = 0;
  longint cycles = 0;
  bit stall_quiet = 1'b0;

  grid_cell_key_vicinity_unit u_top (.*);

  always #2 clk_i = ~clk_i;

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_cell_key_vicinity_unit regression: fail");
      $finish;
    end
  end

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint step_or_one(longint v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint cell_index(longint v2, longint lo2, longint st);
    longint q;
    if (v2 <= lo2) return 0;
    q = (v2 - lo2) / (2 * st);
    return (q > 32767) ? 32767 : q;
  endfunction

  function automatic longint cell_centre(longint k, longint lo2, longint st, longint hi2);
    longint c;
    c = lo2 + st * (2 * k + 1);
    return (c > hi2) ? hi2 : c;
  endfunction

  task automatic span_window(input longint p2, r2, lo2, hi2, st,
                             output longint fst, output longint cnt);
    longint own, hi, lo;
    own = cell_index(p2, lo2, st);
    hi = (p2 + r2 <= hi2) ? cell_index(p2 + r2, lo2, st) : cell_index(hi2, lo2, st);
    lo = (p2 - r2 >= lo2) ? cell_index(p2 - r2, lo2, st) : 0;
    if (own >= (MAX_SPAN - 1) / 2 && lo < own - (MAX_SPAN - 1) / 2)
      lo = own - (MAX_SPAN - 1) / 2;
    if (hi < lo) hi = lo;
    if (hi - lo + 1 > MAX_SPAN) hi = lo + MAX_SPAN - 1;
    fst = lo;
    cnt = hi - lo + 1;
  endtask

  // Adds one beat at the tail of the expected store.
  task automatic expect_cell(input cell_res_t r);
    expected_cells.insert(expected_cells.size(), r);
  endtask

  // Adds one row at the tail of the directed table.
  task automatic add_row(input query_row_t q);
    table_rows.insert(table_rows.size(), q);
  endtask

  // Appends the cell keys that one query gives to the expected store.
  task automatic predict_cells(input query_row_t q);
    longint lx2, ly2, hx2, hy2, sx, sy, r2, px2, py2, kx, ky;
    longint fx, nx, fy, ny, dx, dy;
    bit oor;
    cell_res_t r;
    int n;
    lx2 = 2 * g_min_x; ly2 = 2 * g_min_y; hx2 = 2 * g_max_x; hy2 = 2 * g_max_y;
    sx = step_or_one(g_step_x); sy = step_or_one(g_step_y);
    r2 = 2 * longint'(q.rad);
    n = 0;
    if (q.kind == KIND_NONE) return;
    if (q.kind == KIND_CIRC) begin
      kx = q.ckey >> KEY_BITS;
      ky = q.ckey & 32'h7fff;
      oor = lx2 > hx2 || ly2 > hy2 || kx > cell_index(hx2, lx2, sx) ||
            ky > cell_index(hy2, ly2, sy);
      px2 = oor ? 0 : cell_centre(kx, lx2, sx, hx2);
      py2 = oor ? 0 : cell_centre(ky, ly2, sy, hy2);
    end else begin
      px2 = 2 * sx24(q.px);
      py2 = 2 * sx24(q.py);
      oor = px2 < lx2 || px2 > hx2 || py2 < ly2 || py2 > hy2;
    end
    if (oor) begin
      r = '{key: '0, oor: 1'b1, last: 1'b1};
      expect_cell(r);
      return;
    end
    if (q.kind == KIND_KEY) begin
      r.key = KEY_W'((cell_index(px2, lx2, sx) << KEY_BITS) | cell_index(py2, ly2, sy));
      r.oor = 1'b0;
      r.last = 1'b1;
      expect_cell(r);
      return;
    end
    span_window(px2, r2, lx2, hx2, sx, fx, nx);
    span_window(py2, r2, ly2, hy2, sy, fy, ny);
    for (longint i = fx; i < fx + nx; i++) begin
      for (longint j = fy; j < fy + ny; j++) begin
        if (q.kind == KIND_CIRC) begin
          dx = cell_centre(i, lx2, sx, hx2) - px2;
          dy = cell_centre(j, ly2, sy, hy2) - py2;
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dx > r2 || dy > r2) continue;
          if (dx * dx + dy * dy > r2 * r2) continue;
        end
        r = '{key: KEY_W'((i << KEY_BITS) | j), oor: 1'b0, last: 1'b0};
        expect_cell(r);
        n++;
      end
    end
    if (n > 0) expected_cells[$].last = 1'b1;
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int gap_len();
    if (stall_quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Receiver stall pattern and result check.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= (gap_len() != 0);
  end

  always @(posedge clk_i) begin
    cell_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected beat key=%h oor=%b last=%b", $time,
                 result_key_o, out_of_range_o, last_o);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (result_key_o !== want.key) begin
          $display("%0t: result_key expected %h actual %h", $time, want.key, result_key_o);
          errors++;
        end
        if (out_of_range_o !== want.oor) begin
          $display("%0t: out_of_range expected %b actual %b", $time, want.oor,
                   out_of_range_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  // Within a run of queries valid drops only for a gap; back-to-back beats keep it high.
  task automatic send_query(input query_row_t q);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= q.kind;
    point_x_i <= q.px;
    point_y_i <= q.py;
    cell_key_i <= q.ckey;
    radius_i <= q.rad;
    if (q.typed) expect_cell(q.res);
    else predict_cells(q);
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= COORD_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    case (idx)
      CFG_MIN_X:  g_min_x = sx24(COORD_W'(val));
      CFG_MIN_Y:  g_min_y = sx24(COORD_W'(val));
      CFG_MAX_X:  g_max_x = sx24(COORD_W'(val));
      CFG_MAX_Y:  g_max_y = sx24(COORD_W'(val));
      CFG_STEP_X: g_step_x = val & 32'h7fffff;
      CFG_STEP_Y: g_step_y = val & 32'h7fffff;
      default: ;
    endcase
  endtask

  task automatic set_box(input longint mnx, mny, mxx, mxy, stx, sty);
    write_reg(CFG_MIN_X, mnx);
    write_reg(CFG_MIN_Y, mny);
    write_reg(CFG_MAX_X, mxx);
    write_reg(CFG_MAX_Y, mxy);
    write_reg(CFG_STEP_X, stx);
    write_reg(CFG_STEP_Y, sty);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic query_row_t row(logic [1:0] k, logic [23:0] x, logic [23:0] y,
                                     logic [29:0] ck, logic [22:0] rd);
    query_row_t q;
    q.kind = k; q.px = x; q.py = y; q.ckey = ck; q.rad = rd;
    q.typed = 1'b0; q.res = '0;
    return q;
  endfunction

  function automatic query_row_t typed_row(logic [1:0] k, logic [23:0] x, logic [23:0] y,
                                           logic [29:0] ck, logic [22:0] rd,
                                           logic [29:0] key, logic oor);
    query_row_t q;
    q = row(k, x, y, ck, rd);
    q.typed = 1'b1;
    q.res = '{key: key, oor: oor, last: 1'b1};
    return q;
  endfunction

  // Random query near a box, mostly inside, with small radii mostly.
  function automatic query_row_t random_query();
    query_row_t q;
    longint spanx, spany;
    q.kind = ($urandom_range(0, 29) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
    spanx = g_max_x - g_min_x;
    spany = g_max_y - g_min_y;
    if ($urandom_range(0, 7) == 0 || spanx < 0 || spany < 0) begin
      q.px = 24'($urandom); q.py = 24'($urandom);
    end else begin
      q.px = 24'(g_min_x + longint'($urandom) % (spanx + 1));
      q.py = 24'(g_min_y + longint'($urandom) % (spany + 1));
    end
    if ($urandom_range(0, 5) == 0) q.ckey = 30'($urandom);
    else q.ckey = 30'(($urandom_range(0, 40) << KEY_BITS) | $urandom_range(0, 40));
    case ($urandom_range(0, 9))
      0: q.rad = 23'($urandom);
      1, 2: q.rad = 23'($urandom_range(0, 3) * g_step_x);
      default: q.rad = 23'($urandom_range(0, 4 * 256));
    endcase
    q.typed = 1'b0;
    q.res = '0;
    return q;
  endfunction

  initial begin
    g_min_x = 0; g_min_y = 0; g_max_x = 8388607; g_max_y = 8388607;
    g_step_x = 256; g_step_y = 256;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows on the reset box.
    add_row(typed_row(KIND_KEY, 24'h0, 24'h0, 0, 0, 30'h0, 1'b0));
    add_row(typed_row(KIND_KEY, 24'h7fffff, 24'h7fffff, 0, 0, 30'h3fffffff, 1'b0));
    add_row(typed_row(KIND_KEY, 24'h800000, 24'h0, 0, 0, 30'h0, 1'b1));
    add_row(typed_row(KIND_VIC, 24'h0, 24'hffffff, 0, 5, 30'h0, 1'b1));
    add_row(typed_row(KIND_KEY, 24'h000300, 24'h000500, 0, 0, 30'h18005, 1'b0));
    add_row(row(KIND_VIC, 24'h000400, 24'h000400, 0, 23'h000100));
    add_row(row(KIND_VIC, 24'h0, 24'h0, 0, 23'h7fffff));
    add_row(row(KIND_VIC, 24'h7fffff, 24'h7fffff, 0, 23'h7fffff));
    add_row(row(KIND_VIC, 24'h002000, 24'h002000, 0, 23'h0));
    add_row(row(KIND_CIRC, 0, 0, 30'h00050005, 23'h000200));
    add_row(row(KIND_CIRC, 0, 0, 30'h3fffffff, 23'h7fffff));
    add_row(row(KIND_CIRC, 0, 0, 30'h0, 23'h0));
    add_row(row(KIND_CIRC, 0, 0, 30'h00020002, 23'h000180));
    add_row(row(KIND_NONE, 24'h123456, 24'h654321, 30'h2aaaaaaa, 23'h555555));
    add_row(row(KIND_CIRC, 0, 0, 30'h00090009, 23'h7fffff));
    foreach (table_rows[i]) send_query(table_rows[i]);
    wait_idle();

    // Empty box on x, then zero steps, then a key index past the maximum.
    set_box(24'h100, 0, 0, 24'h7fffff, 256, 256);
    send_query(typed_row(KIND_KEY, 24'h80, 24'h80, 0, 0, 30'h0, 1'b1));
    send_query(typed_row(KIND_CIRC, 0, 0, 30'h0, 23'h100, 30'h0, 1'b1));
    wait_idle();
    set_box(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 0, 0);
    send_query(row(KIND_KEY, 24'h800000, 24'h7fffff, 0, 0));
    send_query(row(KIND_VIC, 24'h000001, 24'h000003, 0, 23'h2));
    send_query(row(KIND_CIRC, 0, 0, 30'h3fffffff, 23'h3));
    wait_idle();
    set_box(0, 0, 24'h000a00, 24'h000a00, 256, 256);
    send_query(typed_row(KIND_CIRC, 0, 0, 30'h000b0000, 23'h100, 30'h0, 1'b1));
    wait_idle();

    // Random phases over several boxes, the extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      stall_quiet = (ph == 3);
      case (ph)
        0: set_box(0, 0, 24'h001000, 24'h001000, 256, 256);
        1: set_box(24'hfff000, 24'hffe000, 24'h000800, 24'h001800, 24'h180, 24'h300);
        2: set_box(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff);
        3: set_box(24'h000100, 24'h000200, 24'h000900, 24'h000600, 1, 24'h40);
        4: set_box(0, 0, 24'h7fffff, 24'h7fffff, 256, 256);
        5: set_box(24'hffff00, 24'hffff00, 24'h000300, 24'h000300, 37, 91);
        6: set_box(24'h000400, 0, 24'h000200, 24'h000400, 256, 256);
        default: set_box(24'h800000, 0, 24'h800100, 24'h002000, 24'h80, 24'h200);
      endcase
      for (int n = 0; n < 50; n++) send_query(random_query());
      wait_idle();
    end

    if (errors == 0) begin
      $display("grid_cell_key_vicinity_unit regression: pass");
    end else begin
      $display("grid_cell_key_vicinity_unit regression: fail");
    end
    $finish;
  end

endmodule
